[rtl/sepq_pkg.sv]
`default_nettype none

package sepq_pkg;

    // Operation codes carried in the input tuser
    localparam logic [1:0] FN_INSERT = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_DELETE = 2'd2;

    // Result status codes carried in the output tuser
    localparam logic [2:0] ST_OK     = 3'd0;
    localparam logic [2:0] ST_EMPTY  = 3'd1;
    localparam logic [2:0] ST_DUP    = 3'd2;
    localparam logic [2:0] ST_FULL   = 3'd3;
    localparam logic [2:0] ST_NOKEY  = 3'd4;
    localparam logic [2:0] ST_HANDLE = 3'd5;

    localparam int TIME_W   = 64;
    localparam int ID_W     = 32;
    localparam int HANDLE_W = 32;
    localparam int COUNT_W  = 7;

    typedef struct packed {
        logic [TIME_W-1:0]   ev_time;
        logic [ID_W-1:0]     ev_id;
        logic [HANDLE_W-1:0] ev_handle;
    } sepq_entry_t;

    // Commands broadcast to every cell
    typedef struct packed {
        logic eval;   // compare the broadcast key against the stored entry
        logic ins;    // open a gap and drop the key into place
        logic del;    // close the gap at and after the matching entry
        logic pop;    // shift the whole chain toward the head
    } sepq_cmd_t;

    // Flags one cell reports back
    typedef struct packed {
        logic valid;
        logic lt;     // key sorts before the stored entry, or the cell is empty
        logic eq;     // stored key equals the broadcast key
        logic hm;     // stored handle equals the broadcast handle
    } sepq_flags_t;

endpackage

`default_nettype wire

[rtl/sepq_cell.sv]
`default_nettype none

module sepq_cell
    import sepq_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire sepq_cmd_t   cmd,
    input  wire sepq_entry_t key,
    input  wire sepq_entry_t left_data,
    input  wire logic        left_valid,
    input  wire logic        left_lt,
    input  wire sepq_entry_t right_data,
    input  wire logic        right_valid,
    output sepq_entry_t      data,
    output sepq_flags_t      flags
);

    sepq_entry_t data_reg;
    logic        valid_reg;
    logic        lt_reg;
    logic        eq_reg;
    logic        hm_reg;

    logic lt_next;
    logic eq_next;
    logic hm_next;

    always_comb
    begin
        lt_next = !valid_reg
                  || (key.ev_time < data_reg.ev_time)
                  || ((key.ev_time == data_reg.ev_time) && (key.ev_id < data_reg.ev_id));
        eq_next = valid_reg && (key.ev_time == data_reg.ev_time)
                  && (key.ev_id == data_reg.ev_id);
        hm_next = (key.ev_handle == data_reg.ev_handle);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
            hm_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                lt_reg <= lt_next;
                eq_reg <= eq_next;
                hm_reg <= hm_next;
            end
            if (cmd.ins && lt_reg)
            begin
                valid_reg <= left_lt ? left_valid : 1'b1;
            end
            if (cmd.pop || (cmd.del && (lt_reg || eq_reg)))
            begin
                valid_reg <= right_valid;
            end
        end
    end

    // Payload: no reset
    always_ff @(posedge clk)
    begin
        if (cmd.ins && lt_reg)
        begin
            data_reg <= left_lt ? left_data : key;
        end
        if (cmd.pop || (cmd.del && (lt_reg || eq_reg)))
        begin
            data_reg <= right_data;
        end
    end

    assign data        = data_reg;
    assign flags.valid = valid_reg;
    assign flags.lt    = lt_reg;
    assign flags.eq    = eq_reg;
    assign flags.hm    = hm_reg;

endmodule

`default_nettype wire

[rtl/sorted_event_priority_queue_unit.sv]
`default_nettype none

// Sorted event priority queue. Entries are (time, id, handle) and stay sorted
// by time, then id, in a chain of CAPACITY cells with the smallest entry in
// cell 0. Each input word (tuser = operation) inserts, pops the head, or
// deletes by key after a handle check; each produces exactly one result word
// with a status, the removed entry, the new head and the entry count. A
// failed operation leaves the queue untouched. Each word goes through these
// steps in order: accept, compare the key in all cells at once, shift the
// chain one place (toward the tail on insert, toward the head on removal),
// and load the output register. The output register holds a result until it
// is taken; a full output register stalls the final step only. No clearing
// pass is needed after reset: in the cells only valid and compare flags clear.
module sorted_event_priority_queue_unit
    import sepq_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output      logic         s_axis_tready,
    // event_time[63:0], event_id[95:64], event_handle[127:96]
    input  wire logic [127:0] s_axis_tdata,
    // func[1:0]
    input  wire logic [1:0]   s_axis_tuser,
    output      logic         m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // removed_time[63:0], removed_id[95:64], removed_handle[127:96],
    // head_time[191:128], head_id[223:192], head_handle[255:224],
    // queue_empty[256], entry_count[263:257]
    output      logic [263:0] m_axis_tdata,
    // status[2:0]
    output      logic [2:0]   m_axis_tuser
);

    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_APPLY  = 4'b0100,
        S_REPORT = 4'b1000
    } state_t;

    state_t       state_reg;
    state_t       state_next;

    logic [1:0]   func_reg;
    sepq_entry_t  key_reg;
    logic [CW-1:0] occ_reg;
    logic [CW-1:0] occ_next;

    logic [2:0]   status_reg;
    logic [2:0]   status_next;
    sepq_entry_t  removed_reg;
    sepq_entry_t  removed_next;

    logic         out_valid_reg;
    logic [263:0] out_data_reg;
    logic [2:0]   out_status_reg;

    sepq_cmd_t    cmd;
    sepq_entry_t  cell_data  [CAPACITY];
    sepq_flags_t  cell_flags [CAPACITY];

    logic [CAPACITY-1:0] valid_vec;
    logic [CAPACITY-1:0] eq_vec;
    logic [CAPACITY-1:0] hm_vec;

    logic         any_eq;
    logic         handle_ok;
    logic         out_free;
    logic         s_fire;

    sepq_entry_t  head;
    logic [CW+COUNT_W-1:0] occ_ext;

    // ------------------------------------------------------------------
    // Cell chain
    // ------------------------------------------------------------------
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        sepq_entry_t left_data;
        logic        left_valid;
        logic        left_lt;
        sepq_entry_t right_data;
        logic        right_valid;

        if (i == 0)
        begin : g_first
            // nothing to the left of the head: an insert that sorts first lands here
            assign left_data  = '0;
            assign left_valid = 1'b0;
            assign left_lt    = 1'b0;
        end
        else
        begin : g_mid
            assign left_data  = cell_data[i-1];
            assign left_valid = cell_flags[i-1].valid;
            assign left_lt    = cell_flags[i-1].lt;
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_data  = '0;
            assign right_valid = 1'b0;
        end
        else
        begin : g_inner
            assign right_data  = cell_data[i+1];
            assign right_valid = cell_flags[i+1].valid;
        end

        sepq_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .key         (key_reg),
            .left_data   (left_data),
            .left_valid  (left_valid),
            .left_lt     (left_lt),
            .right_data  (right_data),
            .right_valid (right_valid),
            .data        (cell_data[i]),
            .flags       (cell_flags[i])
        );

        assign valid_vec[i] = cell_flags[i].valid;
        assign eq_vec[i]    = cell_flags[i].eq;
        assign hm_vec[i]    = cell_flags[i].hm;
    end

    // ------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------
    assign s_axis_tready = (state_reg == S_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    // Keys are unique, so at most one cell matches
    assign any_eq    = |eq_vec;
    assign handle_ok = |(eq_vec & hm_vec);

    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        occ_next     = occ_reg;
        status_next  = status_reg;
        removed_next = removed_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_fire)
                begin
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                cmd.eval   = 1'b1;
                state_next = S_APPLY;
            end
            S_APPLY:
            begin
                status_next  = ST_OK;
                removed_next = '0;
                unique case (func_reg)
                    FN_INSERT:
                    begin
                        if (any_eq)
                        begin
                            status_next = ST_DUP;
                        end
                        else if (occ_reg == CW'(CAPACITY))
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            cmd.ins  = 1'b1;
                            occ_next = occ_reg + CW'(1);
                        end
                    end
                    FN_POP:
                    begin
                        if (occ_reg == '0)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            cmd.pop      = 1'b1;
                            occ_next     = occ_reg - CW'(1);
                            removed_next = cell_data[0];
                        end
                    end
                    FN_DELETE:
                    begin
                        if (!any_eq)
                        begin
                            status_next = ST_NOKEY;
                        end
                        else if (!handle_ok)
                        begin
                            status_next = ST_HANDLE;
                        end
                        else
                        begin
                            // the matched entry equals the requested key and handle
                            cmd.del      = 1'b1;
                            occ_next     = occ_reg - CW'(1);
                            removed_next = key_reg;
                        end
                    end
                    default:
                    begin
                        // unused code: report only
                    end
                endcase
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
            if ((state_reg == S_REPORT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Head after the operation; an empty queue reports zeros
    assign head    = valid_vec[0] ? cell_data[0] : '0;
    assign occ_ext = {{COUNT_W{1'b0}}, occ_reg};

    // Payload registers: no reset
    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            func_reg          <= s_axis_tuser;
            key_reg.ev_time   <= s_axis_tdata[63:0];
            key_reg.ev_id     <= s_axis_tdata[95:64];
            key_reg.ev_handle <= s_axis_tdata[127:96];
        end
        status_reg  <= status_next;
        removed_reg <= removed_next;
        if ((state_reg == S_REPORT) && out_free)
        begin
            out_status_reg <= status_reg;
            out_data_reg   <= {occ_ext[COUNT_W-1:0],
                               !valid_vec[0],
                               head.ev_handle, head.ev_id, head.ev_time,
                               removed_reg.ev_handle, removed_reg.ev_id,
                               removed_reg.ev_time};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CW'(CAPACITY))
        else $error("occupancy above capacity");

    a_valid_count: assert property (@(posedge clk) disable iff (!rst_n)
        CW'($countones(valid_vec)) == occ_reg)
        else $error("valid cells disagree with occupancy");

    a_head_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (occ_reg != '0) == valid_vec[0])
        else $error("head cell valid disagrees with occupancy");

    a_unique_key: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_APPLY) |-> $onehot0(eq_vec))
        else $error("key matched in more than one cell");

    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_REPORT) && out_free) |=> m_axis_tvalid)
        else $error("result not presented after report");

endmodule

`default_nettype wire

[tb/sorted_event_priority_queue_unit_tb.sv]
`default_nettype none

module sorted_event_priority_queue_unit_tb
    import sepq_pkg::*;
();

    localparam int DEPTH      = 64;
    localparam int WORD_GOAL  = 1300;
    localparam int CYCLE_CAP  = 500000;
    localparam int DIR_ROWS   = 21;

    // func code 3 is not named in the package; the block treats it as a no-op
    localparam logic [1:0]  FN_NOP = 2'd3;

    localparam logic [63:0] MAX_T  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] MAX_ID = 32'hFFFF_FFFF;

    // traffic shapes for the random part
    localparam int MODE_FILL  = 0;
    localparam int MODE_MIXED = 1;
    localparam int MODE_DRAIN = 2;

    typedef struct packed {
        logic [1:0]  fn;
        sepq_entry_t ent;
    } op_word_t;

    typedef struct {
        logic [2:0]  status;
        sepq_entry_t removed;
        sepq_entry_t head;
        logic        empty;
        logic [6:0]  count;
    } op_result_t;

    // one directed word; status and count are typed in where pinned is set
    typedef struct packed {
        logic [1:0]  fn;
        logic [63:0] ev_time;
        logic [31:0] ev_id;
        logic [31:0] ev_handle;
        logic        pinned;
        logic [2:0]  st;
        logic [6:0]  cnt;
    } dir_row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [127:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [263:0] m_axis_tdata;
    logic [2:0]   m_axis_tuser;

    sepq_entry_t  held_entries [$];   // mirror of the queue contents, sorted
    op_result_t   due_results  [$];   // results owed by the block, oldest first
    op_result_t   want_res;

    int  fail_cnt;
    int  words_sent;
    int  cycle_cnt;
    bit  send_idle;
    bit  recv_idle;

    dir_row_t dir_rows [DIR_ROWS] = '{
        '{FN_POP,    64'd0, 32'd0,  32'd0,          1'b1, ST_EMPTY,  7'd0},
        '{FN_DELETE, 64'd0, 32'd0,  32'd0,          1'b1, ST_NOKEY,  7'd0},
        '{FN_NOP,    MAX_T, MAX_ID, MAX_ID,         1'b1, ST_OK,     7'd0},
        '{FN_INSERT, MAX_T, MAX_ID, MAX_ID,         1'b1, ST_OK,     7'd1},
        '{FN_INSERT, 64'd0, 32'd0,  32'd0,          1'b1, ST_OK,     7'd2},
        '{FN_INSERT, MAX_T, MAX_ID, 32'd5,          1'b1, ST_DUP,    7'd2},
        '{FN_DELETE, MAX_T, MAX_ID, 32'd0,          1'b1, ST_HANDLE, 7'd2},
        '{FN_DELETE, MAX_T, 32'd0,  MAX_ID,         1'b1, ST_NOKEY,  7'd2},
        '{FN_INSERT, 64'd0, MAX_ID, 32'hA5A5_A5A5,  1'b1, ST_OK,     7'd3},
        '{FN_INSERT, 64'd1, 32'd0,  32'h5A5A_5A5A,  1'b0, ST_OK,     7'd0},
        '{FN_INSERT, MAX_T, 32'd0,  32'd1,          1'b0, ST_OK,     7'd0},
        '{FN_INSERT, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'hDEAD_BEEF,
          1'b0, ST_OK, 7'd0},
        '{FN_NOP,    64'd0, 32'd0,  32'd0,          1'b1, ST_OK,     7'd6},
        '{FN_POP,    64'd0, 32'd0,  32'd0,          1'b1, ST_OK,     7'd5},
        '{FN_DELETE, 64'd0, MAX_ID, 32'hA5A5_A5A5,  1'b1, ST_OK,     7'd4},
        '{FN_DELETE, 64'h8000_0000_0000_0000, 32'h8000_0000, 32'hDEAD_BEEE,
          1'b1, ST_HANDLE, 7'd4},
        '{FN_DELETE, MAX_T, MAX_ID, MAX_ID,         1'b1, ST_OK,     7'd3},
        '{FN_POP,    64'd0, 32'd0,  32'd0,          1'b0, ST_OK,     7'd0},
        '{FN_POP,    64'd0, 32'd0,  32'd0,          1'b0, ST_OK,     7'd0},
        '{FN_POP,    64'd0, 32'd0,  32'd0,          1'b1, ST_OK,     7'd0},
        '{FN_POP,    64'd0, 32'd0,  32'd0,          1'b1, ST_EMPTY,  7'd0}
    };

    sorted_event_priority_queue_unit #(
        .CAPACITY (DEPTH)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Apply one operation to the mirrored queue and return the result word
    // the block owes for it.
    function automatic op_result_t apply_queue_op(input logic [1:0] fn,
                                                  input sepq_entry_t e);
        op_result_t r;
        int         hit;
        int         pos;
        hit = -1;
        for (int k = 0; k < held_entries.size(); k++)
            if (hit < 0 && held_entries[k].ev_time == e.ev_time
                        && held_entries[k].ev_id == e.ev_id)
                hit = k;
        r.status  = ST_OK;
        r.removed = '0;
        case (fn)
            FN_INSERT:
            begin
                // a duplicate key wins over a full queue
                if (hit >= 0)
                    r.status = ST_DUP;
                else if (held_entries.size() >= DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    pos = 0;
                    while (pos < held_entries.size()
                           && {e.ev_time, e.ev_id} >
                              {held_entries[pos].ev_time, held_entries[pos].ev_id})
                        pos++;
                    held_entries.insert(pos, e);
                end
            end
            FN_POP:
            begin
                if (held_entries.size() == 0)
                    r.status = ST_EMPTY;
                else
                    r.removed = held_entries.pop_front();
            end
            FN_DELETE:
            begin
                if (hit < 0)
                    r.status = ST_NOKEY;
                else if (held_entries[hit].ev_handle != e.ev_handle)
                    r.status = ST_HANDLE;
                else
                begin
                    r.removed = held_entries[hit];
                    held_entries.delete(hit);
                end
            end
            default:
                ;
        endcase
        r.empty = (held_entries.size() == 0);
        r.head  = r.empty ? '0 : held_entries[0];
        r.count = 7'(held_entries.size());
        return r;
    endfunction

    // Timestamps crowd a few small values so that ties on time are common.
    function automatic logic [63:0] pick_time();
        case ($urandom_range(0, 3))
            0:       return 64'($urandom_range(0, 7));
            1:       return {$urandom(), $urandom()};
            2:       return $urandom_range(0, 1) ? MAX_T : 64'd0;
            default: return 64'($urandom_range(16, 1000));
        endcase
    endfunction

    function automatic logic [31:0] pick_id();
        case ($urandom_range(0, 3))
            0:       return $urandom_range(0, 3);
            1:       return $urandom_range(0, 1) ? MAX_ID : 32'd0;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [31:0] pick_handle();
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return MAX_ID;
            default: return $urandom();
        endcase
    endfunction

    // Draw one random word, aimed at the current queue contents so that
    // keyed removals and duplicate inserts mostly hit live entries.
    function automatic op_word_t make_word(input int mode);
        op_word_t w;
        int       roll;
        int       ins_pct;
        int       k;
        int       dup_odds;
        ins_pct = (mode == MODE_FILL) ? 90 : (mode == MODE_MIXED) ? 50 : 15;
        roll    = $urandom_range(0, 99);
        w.ent.ev_time   = pick_time();
        w.ent.ev_id     = pick_id();
        w.ent.ev_handle = pick_handle();
        if (roll < 3)
            w.fn = FN_NOP;
        else if (roll < ins_pct)
        begin
            w.fn     = FN_INSERT;
            dup_odds = (held_entries.size() >= DEPTH) ? 3 : 10;
            if (held_entries.size() > 0 && $urandom_range(1, dup_odds) == 1)
            begin
                k = $urandom_range(0, held_entries.size() - 1);
                w.ent.ev_time = held_entries[k].ev_time;
                w.ent.ev_id   = held_entries[k].ev_id;
            end
        end
        else if (roll < ins_pct + (100 - ins_pct) / 2)
            w.fn = FN_POP;
        else
        begin
            w.fn = FN_DELETE;
            if (held_entries.size() > 0 && $urandom_range(0, 4) != 4)
            begin
                k     = $urandom_range(0, held_entries.size() - 1);
                w.ent = held_entries[k];
                // flip at least one handle bit now and then
                if ($urandom_range(0, 3) == 0)
                    w.ent.ev_handle = w.ent.ev_handle ^ ($urandom() | 32'd1);
            end
        end
        return w;
    endfunction

    // Present one word after a random gap and hold it until accepted, then
    // record the result it owes. Valid stays high into the next word when
    // no gap is drawn.
    task automatic send_word(input op_word_t w, input logic pinned,
                             input logic [2:0] pin_st, input logic [6:0] pin_cnt);
        int         gap;
        op_result_t res;
        gap = send_idle ? $urandom_range(0, 19) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {w.ent.ev_handle, w.ent.ev_id, w.ent.ev_time};
        s_axis_tuser  <= w.fn;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        res = apply_queue_op(w.fn, w.ent);
        if (pinned)
        begin
            res.status = pin_st;
            res.count  = pin_cnt;
        end
        due_results.push_back(res);
        words_sent++;
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic hold_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic report_fail(input string msg);
        if (fail_cnt < 10)
            $display("MISMATCH: %s", msg);
        fail_cnt++;
    endtask

    task automatic compare_field(input string name, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got)
            report_fail($sformatf("%s expected %h, got %h", name, want, got));
    endtask

    // Result sink: stall a random number of cycles before each word.
    initial
    begin : sink
        int stall;
        m_axis_tready = 1'b0;
        @(negedge clk);
        forever
        begin
            stall = recv_idle ? $urandom_range(0, 19) : 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Check every result word against the oldest owed result.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_results.size() == 0)
                report_fail($sformatf("result word with none owed, status %0d",
                                      m_axis_tuser));
            else
            begin
                want_res = due_results.pop_front();
                compare_field("status", 64'(want_res.status), 64'(m_axis_tuser));
                compare_field("removed_time", want_res.removed.ev_time,
                              m_axis_tdata[63:0]);
                compare_field("removed_id", 64'(want_res.removed.ev_id),
                              64'(m_axis_tdata[95:64]));
                compare_field("removed_handle", 64'(want_res.removed.ev_handle),
                              64'(m_axis_tdata[127:96]));
                compare_field("head_time", want_res.head.ev_time,
                              m_axis_tdata[191:128]);
                compare_field("head_id", 64'(want_res.head.ev_id),
                              64'(m_axis_tdata[223:192]));
                compare_field("head_handle", 64'(want_res.head.ev_handle),
                              64'(m_axis_tdata[255:224]));
                compare_field("queue_empty", 64'(want_res.empty),
                              64'(m_axis_tdata[256]));
                compare_field("entry_count", 64'(want_res.count),
                              64'(m_axis_tdata[263:257]));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        op_word_t w;
        int       phase;
        int       mode;
        int       len;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        send_idle     = 1'b0;
        recv_idle     = 1'b0;
        fail_cnt      = 0;
        words_sent    = 0;
        cycle_cnt     = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words: empty queue, extremes, every failure status but full
        send_idle = 1'b1;
        recv_idle = 1'b1;
        for (int r = 0; r < DIR_ROWS; r++)
        begin
            w.fn            = dir_rows[r].fn;
            w.ent.ev_time   = dir_rows[r].ev_time;
            w.ent.ev_id     = dir_rows[r].ev_id;
            w.ent.ev_handle = dir_rows[r].ev_handle;
            send_word(w, dir_rows[r].pinned, dir_rows[r].st, dir_rows[r].cnt);
        end
        hold_until_drained();

        // random phases cycle fill, mixed and drain traffic so the queue
        // swings between empty and full; every fourth phase runs flat out
        phase = 0;
        while (words_sent < WORD_GOAL)
        begin
            mode      = phase % 3;
            len       = (mode == MODE_FILL) ? 130 : 100;
            send_idle = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
            recv_idle = (phase % 4 != 1) && ($urandom_range(0, 3) != 0);
            for (int i = 0; i < len; i++)
            begin
                w = make_word(mode);
                send_word(w, 1'b0, ST_OK, 7'd0);
            end
            hold_until_drained();
            phase++;
        end

        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (fail_cnt == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

`default_nettype wire
